@@ rtl/bcu_pkg.sv @@
// Shared types for the binomial coefficient unit.
// No dependencies.
package bcu_pkg;

  // What the sequencer is waiting on the shared divider for.
  typedef enum logic [1:0] {
    WLim = 2'd0,  // overflow limit ALLMAX / n
    WGcd = 2'd1,  // one Euclid step
    WRed = 2'd2,  // one cancellation step
    WQ   = 2'd3   // exact quotient that closes a round
  } div_use_e;

endpackage

@@ rtl/bcu_divider.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
// No other dependencies.
module bcu_divider #(
  parameter int unsigned WordBits = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] dividend_i,
  input  logic [WordBits-1:0] divisor_i,
  output logic                done_o,
  output logic [WordBits-1:0] quot_o,
  output logic [WordBits-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(WordBits + 1);

  logic [WordBits-1:0] quot_q, rem_q, dvs_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q, done_q;
  logic [WordBits:0]   trial;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem_q, quot_q[WordBits-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WordBits);
        quot_q <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        if (trial[WordBits]) begin
          rem_q <= {rem_q[WordBits-2:0], quot_q[WordBits-1]};
          quot_q <= {quot_q[WordBits-2:0], 1'b0};
        end else begin
          rem_q <= trial[WordBits-1:0];
          quot_q <= {quot_q[WordBits-2:0], 1'b1};
        end
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider failed to start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != '0)
    else $error("divider count underflow");
endmodule

@@ rtl/binomial_coefficient_unit.sv @@
// Binomial coefficient unit: C(n,k) by the multiplicative method.
// Sequence: k=0, k=1 and k>=n go from acceptance straight to the output state. Otherwise a
// plain round runs a limit division, a shift-add multiply and an exact division; a round
// that cancels common factors adds further divisions, some five plus the Euclid steps.
// At most about 34 rounds run for a 64-bit word.
// Throughput: one request at a time; s_axis_tready is low until the result is registered.
// Reset (rst_ni, asynchronous, active low) returns the sequencer to idle.
module binomial_coefficient_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // [63:0] n_value, [127:64] k_value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // [63:0] coefficient
  output logic         m_axis_tuser   // [0] overflowed
);
  import bcu_pkg::*;

  localparam int unsigned W = WORD_BITS;
  localparam logic [W-1:0] AllMax = '1;

  typedef enum logic [3:0] {
    StIdle, StSetup, StDivWait, StG1, StG2, StReduce, StMul, StMulRun, StOut
  } state_e;

  state_e state_q;
  logic [W-1:0] n_q, k_q, r_q, d_q, nr_q, dr_q, ga_q, gb_q, lim_q;
  logic         ovf_q;
  div_use_e     wait_q;  // what the pending division serves
  logic [W-1:0] res_q;
  logic         res_ovf_q, out_v_q;
  logic [W-1:0] mul_acc_q, mul_a_q, mul_b_q;

  logic         div_start_q;
  logic [W-1:0] div_a_q, div_b_q, div_q, div_r;
  logic         div_done;

  bcu_divider #(.WordBits(W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .dividend_i(div_a_q),
    .divisor_i(div_b_q), .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  logic [W-1:0] in_n, in_k;
  assign in_n = s_axis_tdata[W-1:0];
  assign in_k = s_axis_tdata[64+W-1:64];

  // Sequencer driving the shared divider and the shift-add multiplier.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_v_q     <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        StIdle: if (s_axis_tvalid) begin
          n_q <= in_n; ovf_q <= 1'b0; d_q <= W'(1);
          k_q <= (in_k > (in_n >> 1)) ? in_n - in_k : in_k;
          if (in_k == '0) begin r_q <= W'(1); state_q <= StOut; end
          else if (in_k == W'(1)) begin r_q <= in_n; state_q <= StOut; end
          else if (in_k >= in_n) begin
            r_q <= (in_k == in_n) ? W'(1) : '0; state_q <= StOut;
          end else begin
            r_q <= W'(1); state_q <= StSetup;
          end
        end
        // Start of one round: limit = ALLMAX / n; once d exceeds k, go to the output.
        StSetup: begin
          if (d_q > k_q) state_q <= StOut;
          else begin
            div_a_q <= AllMax; div_b_q <= n_q; div_start_q <= 1'b1;
            wait_q <= WLim; state_q <= StDivWait;
          end
        end
        StDivWait: begin
          div_start_q <= 1'b0;
          if (div_done) begin
            case (wait_q)
              WLim: begin
                lim_q <= div_q;
                if (r_q >= div_q) begin
                  ga_q <= n_q; gb_q <= d_q; state_q <= StG1;
                end else begin
                  nr_q <= n_q; dr_q <= d_q; state_q <= StMul;
                end
              end
              WGcd: begin
                ga_q <= gb_q; gb_q <= div_r;
                state_q <= (ovf_q) ? StG2 : StG1;
              end
              WRed: begin
                // Steps of reductions chained through the ga_q selector.
                nr_q <= div_q; state_q <= StReduce;
              end
              default: begin
                r_q <= div_q; d_q <= d_q + W'(1); n_q <= n_q - W'(1);
                state_q <= StSetup;
              end
            endcase
          end
        end
        // First gcd(n, d); ovf_q used as phase flag until finish.
        StG1: begin
          if (gb_q == '0) begin
            lim_q <= ga_q; // g
            div_a_q <= n_q; div_b_q <= ga_q; div_start_q <= 1'b1;
            wait_q <= WRed; ga_q <= '0; state_q <= StDivWait;
          end else begin
            div_a_q <= ga_q; div_b_q <= gb_q; div_start_q <= 1'b1;
            wait_q <= WGcd; state_q <= StDivWait;
          end
        end
        // Reduction steps; ga_q counts which one.
        StReduce: begin
          if (ga_q == '0) begin
            ga_q <= W'(1); gb_q <= nr_q; // save nr
            div_a_q <= d_q; div_b_q <= lim_q; div_start_q <= 1'b1;
            wait_q <= WRed; state_q <= StDivWait;
          end else if (ga_q == W'(1)) begin
            dr_q <= nr_q; nr_q <= gb_q;
            ga_q <= r_q; gb_q <= nr_q; ovf_q <= 1'b1; state_q <= StG2;
          end else if (ga_q == W'(2)) begin
            r_q <= nr_q; ga_q <= W'(3);
            div_a_q <= dr_q; div_b_q <= lim_q; div_start_q <= 1'b1;
            wait_q <= WRed; state_q <= StDivWait;
          end else if (ga_q == W'(3)) begin
            dr_q <= nr_q; nr_q <= gb_q; ga_q <= W'(4);
            if (nr_q == '0 || gb_q == '0) begin
              r_q <= '0; ovf_q <= 1'b1; state_q <= StOut;
            end else begin
              div_a_q <= AllMax; div_b_q <= gb_q; div_start_q <= 1'b1;
              wait_q <= WRed; state_q <= StDivWait;
            end
          end else begin
            nr_q <= gb_q;
            if (r_q >= nr_q) begin
              r_q <= '0; ovf_q <= 1'b1; state_q <= StOut;
            end else state_q <= StMul;
          end
        end
        // Second gcd(r, dr); result goes to lim_q then reduces r, nr is kept in gb_q.
        StG2: begin
          if (gb_q == '0) begin
            lim_q <= (ga_q == '0) ? W'(1) : ga_q;
            gb_q <= nr_q;
            div_a_q <= r_q; div_b_q <= (ga_q == '0) ? W'(1) : ga_q;
            div_start_q <= 1'b1; ovf_q <= 1'b0; ga_q <= W'(2);
            wait_q <= WRed; state_q <= StDivWait;
          end else begin
            div_a_q <= ga_q; div_b_q <= gb_q; div_start_q <= 1'b1;
            wait_q <= WGcd; state_q <= StDivWait;
          end
        end
        // Load the shift-add multiplier with r and nr.
        StMul: begin
          mul_acc_q <= '0; mul_a_q <= r_q; mul_b_q <= nr_q;
          state_q <= StMulRun;
        end
        // One multiplier bit per cycle, then divide the product by dr.
        StMulRun: begin
          if (mul_b_q == '0) begin
            div_a_q <= mul_acc_q; div_b_q <= dr_q; div_start_q <= 1'b1;
            wait_q <= WQ; state_q <= StDivWait;
          end else begin
            if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
            mul_a_q <= mul_a_q << 1;
            mul_b_q <= mul_b_q >> 1;
          end
        end
        StOut: if (!out_v_q) begin
          res_q <= r_q; res_ovf_q <= ovf_q && (r_q == '0);
          out_v_q <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = 64'(res_q);
  assign m_axis_tuser  = res_ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted a request while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == '0)
    else $error("overflow with nonzero result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> state_q == StDivWait)
    else $error("divider started outside a wait");
endmodule

@@ tb/sv/binomial_coefficient_unit_tb.sv @@
// Self-checking testbench for binomial_coefficient_unit.
// Drives (n, k) requests, predicts C(n, k) and the overflow flag, and checks every result.
// Depends on the RTL in rtl/ only.
`timescale 1ns / 1ps

module binomial_coefficient_unit_tb;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int unsigned NUM_RANDOM = 80;

  typedef struct packed {
    logic [63:0] coefficient;
    logic        overflowed;
  } coef_result_t;

  typedef struct {
    logic [63:0] n_value;
    logic [63:0] k_value;
    logic        typed;
    logic [63:0] coefficient;
    logic        overflowed;
  } coef_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;

  coef_result_t pending_coefs[$];
  int unsigned  error_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  overflow_seen = 0;
  int unsigned  quiet_cycles = 0;
  bit           drain_ready_always = 1'b0;

  always #6 clk_i = ~clk_i;

  binomial_coefficient_unit #(.WORD_BITS(WORD_BITS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Euclid's algorithm on full words.
  function automatic logic [63:0] word_gcd(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Multiplicative binomial with the conservative overflow exit.
  function automatic coef_result_t binomial_of(logic [63:0] n_in, logic [63:0] k_in);
    logic [63:0]  allmax;
    logic [63:0]  n;
    logic [63:0]  k;
    logic [63:0]  r;
    logic [63:0]  g;
    logic [63:0]  g2;
    logic [63:0]  nr;
    logic [63:0]  dr;
    coef_result_t res;
    allmax = {64{1'b1}} >> (64 - WORD_BITS);
    n = n_in & allmax;
    k = k_in & allmax;
    r = 1;
    res.overflowed = 1'b0;
    if (k == 0) r = 1;
    else if (k == 1) r = n;
    else if (k >= n) r = (k == n) ? 64'd1 : 64'd0;
    else begin
      if (k > n / 2) k = n - k;
      for (logic [63:0] d = 1; d <= k; d++) begin
        if (n == 0) break;
        if (r >= allmax / n) begin
          g = word_gcd(n, d);
          nr = n / g;
          dr = d / g;
          g2 = word_gcd(r, dr);
          if (g2 == 0) g2 = 1;
          r = r / g2;
          dr = dr / g2;
          if (nr == 0 || dr == 0 || r >= allmax / nr) begin
            r = 0;
            res.overflowed = 1'b1;
            break;
          end
          r = ((r * nr) & allmax) / dr;
        end else begin
          r = ((r * n) & allmax) / d;
        end
        n--;
      end
    end
    res.coefficient = r & allmax;
    return res;
  endfunction

  // Result side: random stall, compare against the oldest expectation.
  always @(posedge clk_i) begin
    coef_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser) overflow_seen++;
        if (pending_coefs.size() == 0) begin
          $error("unexpected result: coefficient %0d overflowed %0b", m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          want = pending_coefs.pop_front();
          if (m_axis_tdata !== want.coefficient) begin
            $error("coefficient: expected %0d, actual %0d", want.coefficient, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tuser !== want.overflowed) begin
            $error("overflowed: expected %0b, actual %0b", want.overflowed, m_axis_tuser);
            error_count++;
          end
        end
      end
      m_axis_tready <= drain_ready_always || ($urandom_range(99) >= 36);
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("binomial_coefficient_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, with optional random gaps, and queue its expected result.
  // The valid line stays high after acceptance until a gap or the caller drops it.
  task automatic send_request(logic [63:0] n, logic [63:0] k, bit allow_gaps);
    while (allow_gaps && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {k, n};
    pending_coefs.push_back(binomial_of(n, k));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_for_results();
    while (pending_coefs.size() != 0) @(posedge clk_i);
  endtask

  // Random operands biased towards small, interesting values.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(70));
      2: return 64'($urandom_range(1000));
      default: return 64'($urandom_range(200000));
    endcase
  endfunction

  initial begin
    coef_row_t    rows[$];
    coef_result_t got;
    logic [63:0]  n;
    logic [63:0]  k;
    rows = '{
      '{64'd0,  64'd0,  1'b1, 64'd1, 1'b0},
      '{64'd5,  64'd0,  1'b1, 64'd1, 1'b0},
      '{64'd0,  64'd1,  1'b1, 64'd0, 1'b0},
      '{64'd7,  64'd1,  1'b1, 64'd7, 1'b0},
      '{64'd9,  64'd9,  1'b1, 64'd1, 1'b0},
      '{64'd3,  64'd8,  1'b1, 64'd0, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd1, 1'b0},
      '{64'd5,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b1, 64'd1, 1'b0},
      '{64'd4,  64'd2,  1'b1, 64'd6, 1'b0},
      '{64'd10, 64'd7,  1'b0, 64'd0, 1'b0},
      '{64'd52, 64'd5,  1'b0, 64'd0, 1'b0},
      '{64'd66, 64'd33, 1'b0, 64'd0, 1'b0},
      '{64'd67, 64'd33, 1'b0, 64'd0, 1'b0},
      '{64'd68, 64'd34, 1'b0, 64'd0, 1'b0},
      '{64'd100, 64'd50, 1'b0, 64'd0, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 1'b0, 64'd0, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 64'd0, 1'b0},
      '{64'h0000_0001_0000_0000, 64'd2, 1'b0, 64'd0, 1'b0},
      '{64'h5555_5555_AAAA_AAAA, 64'd3, 1'b0, 64'd0, 1'b0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: typed rows must agree with the predictor as well.
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        got = binomial_of(rows[i].n_value, rows[i].k_value);
        if (got.coefficient !== rows[i].coefficient || got.overflowed !== rows[i].overflowed) begin
          $error("table row %0d: expected %0d/%0b, predicted %0d/%0b", i, rows[i].coefficient,
                 rows[i].overflowed, got.coefficient, got.overflowed);
          error_count++;
        end
      end
      send_request(rows[i].n_value, rows[i].k_value, 1'b1);
    end
    s_axis_tvalid <= 1'b0;

    // Hold off the sender until the block has drained.
    wait_for_results();

    // Random requests; the middle stretch runs with neither side idling.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      drain_ready_always = (i >= 40 && i < 60);
      n = pick_operand();
      case ($urandom_range(3))
        0: k = pick_operand();
        1: k = (n > 0) ? 64'($urandom_range(64)) % n : 64'd0;
        2: k = (n > 1) ? n - 64'($urandom_range(40)) % n : n;
        default: k = 64'($urandom_range(70));
      endcase
      send_request(n, k, !drain_ready_always);
    end
    s_axis_tvalid <= 1'b0;
    drain_ready_always = 1'b0;

    wait_for_results();
    repeat (200) @(posedge clk_i);

    $display("Checked %0d results (%0d with the overflow exit) from %0d directed and %0d random requests.",
             results_seen, overflow_seen, rows.size(), NUM_RANDOM);
    if (error_count == 0 && pending_coefs.size() == 0) begin
      $display("binomial_coefficient_unit_tb: clean");
    end else begin
      $display("binomial_coefficient_unit_tb: errors");
    end
    $finish;
  end

endmodule
